// ===== design/battery_gauge_status_tracker_defines.svh =====
// Assertion macros shared by the battery gauge modules.
// No dependencies; included by the files that carry assertions.
`ifndef BATTERY_GAUGE_STATUS_TRACKER_DEFINES_SVH
`define BATTERY_GAUGE_STATUS_TRACKER_DEFINES_SVH

// Clocked check, disabled while reset is asserted (active low).
`define BGST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define BGST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/bgst_pkg.sv =====
// Shared types, codes and constants of the battery gauge status tracker.
// No dependencies; used by bgst_datapath, bgst_ctrl and the top level.
package bgst_pkg;

    typedef logic [2:0] t_step;

    localparam t_step STEP_NONE    = 3'd0;
    localparam t_step STEP_SCALE   = 3'd1;
    localparam t_step STEP_RECIP   = 3'd2;
    localparam t_step STEP_RATIO   = 3'd3;
    localparam t_step STEP_SEGMENT = 3'd4;
    localparam t_step STEP_SEG_MUL = 3'd5;

    typedef struct packed {
        logic  load;
        t_step step;
        logic  apply;
    } t_dp_cmd;

    typedef struct packed {
        logic sample_ok;
    } t_dp_status;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_LOW_THRESHOLD  = 2'd0;
    localparam t_cfg_idx CFG_DIVIDER_RATIO  = 2'd1;
    localparam t_cfg_idx CFG_CHARGE_ACTIVE  = 2'd2;
    localparam t_cfg_idx CFG_CHARGE_PRESENT = 2'd3;

    localparam int CFG_DATA_W = 12;
    localparam int LEVEL_W    = 7;
    localparam int MV_W       = 16;
    localparam int SENSED_W   = 12;
    localparam int RATIO_W    = 12;
    localparam int X20_W      = 13;

    localparam logic [LEVEL_W-1:0]    RST_LOW_THRESHOLD = 7'd20;
    localparam logic [RATIO_W-1:0]    RST_DIVIDER_RATIO = 12'd512;
    localparam logic [SENSED_W-1:0]   ADC_REF_MV        = 12'd3300;
    localparam logic [LEVEL_W-1:0]    LEVEL_FULL        = 7'd100;

    // segment codes: at or below the first breakpoint, five ramps, at or above full
    typedef logic [2:0] t_seg;
    localparam t_seg SEG_BELOW = 3'd0;
    localparam t_seg SEG_1     = 3'd1;
    localparam t_seg SEG_2     = 3'd2;
    localparam t_seg SEG_3     = 3'd3;
    localparam t_seg SEG_4     = 3'd4;
    localparam t_seg SEG_5     = 3'd5;
    localparam t_seg SEG_ABOVE = 3'd6;

    localparam logic [MV_W-1:0] BP_MV_0 = 16'd3300;
    localparam logic [MV_W-1:0] BP_MV_1 = 16'd3520;
    localparam logic [MV_W-1:0] BP_MV_2 = 16'd3640;
    localparam logic [MV_W-1:0] BP_MV_3 = 16'd3760;
    localparam logic [MV_W-1:0] BP_MV_4 = 16'd3880;
    localparam logic [MV_W-1:0] BP_MV_5 = 16'd4000;

    // (delta * 20) / span by reciprocal; exact for products below 2^13
    localparam int SEG_SHIFT   = 21;
    localparam int SEG_RECIP_W = 15;
    localparam logic [SEG_RECIP_W-1:0] SEG_RECIP_220 = 15'(((1 << SEG_SHIFT) + 219) / 220);
    localparam logic [SEG_RECIP_W-1:0] SEG_RECIP_120 = 15'(((1 << SEG_SHIFT) + 119) / 120);

    function automatic t_seg seg_of_mv(input logic [MV_W-1:0] mv);
        t_seg seg;
        if (mv <= BP_MV_0)     seg = SEG_BELOW;
        else if (mv < BP_MV_1) seg = SEG_1;
        else if (mv < BP_MV_2) seg = SEG_2;
        else if (mv < BP_MV_3) seg = SEG_3;
        else if (mv < BP_MV_4) seg = SEG_4;
        else if (mv < BP_MV_5) seg = SEG_5;
        else                   seg = SEG_ABOVE;
        return seg;
    endfunction

    function automatic logic [MV_W-1:0] seg_lo_mv(input t_seg seg);
        logic [MV_W-1:0] mv;
        case (seg)
            SEG_1:   mv = BP_MV_0;
            SEG_2:   mv = BP_MV_1;
            SEG_3:   mv = BP_MV_2;
            SEG_4:   mv = BP_MV_3;
            SEG_5:   mv = BP_MV_4;
            default: mv = BP_MV_0;
        endcase
        return mv;
    endfunction

    function automatic logic [LEVEL_W-1:0] seg_lo_pct(input t_seg seg);
        logic [LEVEL_W-1:0] pct;
        case (seg)
            SEG_2:     pct = 7'd20;
            SEG_3:     pct = 7'd40;
            SEG_4:     pct = 7'd60;
            SEG_5:     pct = 7'd80;
            SEG_ABOVE: pct = LEVEL_FULL;
            default:   pct = 7'd0;
        endcase
        return pct;
    endfunction

    function automatic logic [SEG_RECIP_W-1:0] seg_recip(input t_seg seg);
        logic [SEG_RECIP_W-1:0] r;
        case (seg)
            SEG_1:   r = SEG_RECIP_220;
            default: r = SEG_RECIP_120;
        endcase
        return r;
    endfunction

endpackage

// ===== design/bgst_datapath.sv =====
// Datapath: config registers, shared multiplier, segment mapper, status state
// and output register. Depends on bgst_pkg; driven by bgst_ctrl commands.
module bgst_datapath #(
    parameter int ADC_BITS     = 12,
    parameter int VERSION_BITS = 32,
    parameter int IN_W         = 16,
    parameter int OUT_W        = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  bgst_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [bgst_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [IN_W-1:0]                 i_req_data,
    input  logic                            i_req_op,
    input  bgst_pkg::t_dp_cmd               i_cmd,
    output bgst_pkg::t_dp_status            o_status,
    output logic [OUT_W-1:0]                o_res_data
);

    localparam int A_W = ADC_BITS + 12;
    localparam int B_W = ADC_BITS + 13;
    localparam int PW  = A_W + B_W;
    localparam int K   = 2 * ADC_BITS + 12;
    localparam logic [63:0] ADC_MAX    = (64'd1 << ADC_BITS) - 64'd1;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << K) + ADC_MAX - 64'd1) / ADC_MAX;
    localparam logic [B_W-1:0] RECIP   = RECIP_FULL[B_W-1:0];
    localparam int RES_W = 4 + bgst_pkg::LEVEL_W + VERSION_BITS;

    logic [bgst_pkg::LEVEL_W-1:0] r_thr;
    logic [bgst_pkg::RATIO_W-1:0] r_ratio;
    logic                         r_active;
    logic                         r_present;

    logic                r_op;
    logic [ADC_BITS-1:0] r_raw;
    logic                r_ok;
    logic                r_pin;
    logic                r_usb;

    logic [PW-1:0]                r_prod;
    bgst_pkg::t_seg               r_seg;
    logic [bgst_pkg::X20_W-1:0]   r_x20;

    logic                         r_avail;
    logic                         r_charging;
    logic                         r_low;
    logic                         r_usb_link;
    logic [bgst_pkg::LEVEL_W-1:0] r_level;
    logic [VERSION_BITS-1:0]      r_version;
    logic [OUT_W-1:0]             r_out;

    logic [A_W-1:0]                 w_mul_a;
    logic [B_W-1:0]                 w_mul_b;
    logic [PW-1:0]                  w_prod;
    logic                           w_mul_en;
    logic [bgst_pkg::SENSED_W-1:0]  w_sensed;
    logic [bgst_pkg::MV_W-1:0]      w_mv;
    bgst_pkg::t_seg                 w_seg;
    logic [bgst_pkg::MV_W-1:0]      w_delta;
    logic [bgst_pkg::X20_W-1:0]     w_x20;
    logic [4:0]                     w_quot;
    logic [bgst_pkg::LEVEL_W-1:0]   w_level;

    logic                         w_sample;
    logic                         w_apply_en;
    logic                         w_charging;
    logic                         n_avail;
    logic                         n_charging;
    logic                         n_low;
    logic                         n_usb_link;
    logic [bgst_pkg::LEVEL_W-1:0] n_level;
    logic [VERSION_BITS-1:0]      n_version;
    logic                         w_changed;
    logic [RES_W-1:0]             w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= bgst_pkg::RST_LOW_THRESHOLD;
            r_ratio   <= bgst_pkg::RST_DIVIDER_RATIO;
            r_active  <= 1'b1;
            r_present <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bgst_pkg::CFG_LOW_THRESHOLD:  r_thr     <= i_cfg_data[bgst_pkg::LEVEL_W-1:0];
                bgst_pkg::CFG_DIVIDER_RATIO:  r_ratio   <= i_cfg_data[bgst_pkg::RATIO_W-1:0];
                bgst_pkg::CFG_CHARGE_ACTIVE:  r_active  <= i_cfg_data[0];
                bgst_pkg::CFG_CHARGE_PRESENT: r_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_req_op;
            r_raw <= i_req_data[ADC_BITS-1:0];
            r_ok  <= i_req_data[ADC_BITS];
            r_pin <= i_req_data[ADC_BITS+1];
            r_usb <= i_req_data[ADC_BITS+2];
        end
    end

    assign w_sensed = r_prod[K+bgst_pkg::SENSED_W-1:K];
    assign w_mv     = r_prod[bgst_pkg::MV_W+7:8];

    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_mul_en = 1'b1;
        case (i_cmd.step)
            bgst_pkg::STEP_SCALE: begin
                w_mul_a = {{(A_W-ADC_BITS){1'b0}}, r_raw};
                w_mul_b = {{(B_W-bgst_pkg::SENSED_W){1'b0}}, bgst_pkg::ADC_REF_MV};
            end
            bgst_pkg::STEP_RECIP: begin
                w_mul_a = r_prod[A_W-1:0];
                w_mul_b = RECIP;
            end
            bgst_pkg::STEP_RATIO: begin
                w_mul_a = {{(A_W-bgst_pkg::SENSED_W){1'b0}}, w_sensed};
                w_mul_b = {{(B_W-bgst_pkg::RATIO_W){1'b0}}, r_ratio};
            end
            bgst_pkg::STEP_SEG_MUL: begin
                w_mul_a = {{(A_W-bgst_pkg::X20_W){1'b0}}, r_x20};
                w_mul_b = {{(B_W-bgst_pkg::SEG_RECIP_W){1'b0}}, bgst_pkg::seg_recip(r_seg)};
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    assign w_prod  = {{B_W{1'b0}}, w_mul_a} * {{A_W{1'b0}}, w_mul_b};
    assign w_seg   = bgst_pkg::seg_of_mv(w_mv);
    assign w_delta = w_mv - bgst_pkg::seg_lo_mv(w_seg);
    assign w_x20   = {5'd0, w_delta[7:0]} * 13'd20;

    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.step == bgst_pkg::STEP_SEGMENT) begin
            r_seg <= w_seg;
            r_x20 <= w_x20;
        end
    end

    assign w_quot = r_prod[bgst_pkg::SEG_SHIFT+4:bgst_pkg::SEG_SHIFT];

    always_comb begin
        case (r_seg)
            bgst_pkg::SEG_BELOW: w_level = '0;
            bgst_pkg::SEG_ABOVE: w_level = bgst_pkg::LEVEL_FULL;
            default:             w_level = bgst_pkg::seg_lo_pct(r_seg) + {2'b00, w_quot};
        endcase
    end

    assign w_sample   = !r_op && r_ok;
    assign w_apply_en = r_op || r_ok;
    assign w_charging = r_present && (r_pin == r_active);

    always_comb begin
        n_charging = w_apply_en ? w_charging : r_charging;
        n_usb_link = w_apply_en ? r_usb : r_usb_link;
        n_avail    = w_sample ? 1'b1 : r_avail;
        n_level    = w_sample ? w_level : r_level;
        n_low      = w_apply_en ? (n_avail && (n_level < r_thr)) : r_low;
        w_changed  = (n_avail != r_avail) || (n_charging != r_charging) ||
                     (n_low != r_low) || (n_usb_link != r_usb_link) ||
                     (n_level != r_level);
        n_version  = w_changed ? r_version + {{(VERSION_BITS-1){1'b0}}, 1'b1} : r_version;
        w_res      = {n_version, n_level, n_usb_link, n_low, n_charging, n_avail};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail    <= 1'b0;
            r_charging <= 1'b0;
            r_low      <= 1'b0;
            r_usb_link <= 1'b0;
            r_level    <= '0;
            r_version  <= '0;
        end else if (i_cmd.apply) begin
            r_avail    <= n_avail;
            r_charging <= n_charging;
            r_low      <= n_low;
            r_usb_link <= n_usb_link;
            r_level    <= n_level;
            r_version  <= n_version;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_out <= {{(OUT_W-RES_W){1'b0}}, w_res};
        end
    end

    assign o_status.sample_ok = w_sample;
    assign o_res_data         = r_out;

endmodule

// ===== design/bgst_ctrl.sv =====
// Controller: sequences the datapath steps per request and owns both handshakes.
// Depends on bgst_pkg and battery_gauge_status_tracker_defines.svh.
`include "battery_gauge_status_tracker_defines.svh"

module bgst_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_valid,
    output logic                 o_s_ready,
    output logic                 o_m_valid,
    input  logic                 i_m_ready,
    input  bgst_pkg::t_dp_status i_status,
    output bgst_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCALE   = 3'd1;
    localparam logic [2:0] S_RECIP   = 3'd2;
    localparam logic [2:0] S_RATIO   = 3'd3;
    localparam logic [2:0] S_SEGMENT = 3'd4;
    localparam logic [2:0] S_SEG_MUL = 3'd5;
    localparam logic [2:0] S_APPLY   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_oval;
    logic       n_oval;
    logic       w_accept;
    logic       w_slot_free;

    assign w_accept    = i_s_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_oval || i_m_ready;

    always_comb begin
        n_state = r_state;
        n_oval  = r_oval && !i_m_ready;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.step = bgst_pkg::STEP_SCALE;
                n_state    = i_status.sample_ok ? S_RECIP : S_APPLY;
            end
            S_RECIP: begin
                o_cmd.step = bgst_pkg::STEP_RECIP;
                n_state    = S_RATIO;
            end
            S_RATIO: begin
                o_cmd.step = bgst_pkg::STEP_RATIO;
                n_state    = S_SEGMENT;
            end
            S_SEGMENT: begin
                o_cmd.step = bgst_pkg::STEP_SEGMENT;
                n_state    = S_SEG_MUL;
            end
            S_SEG_MUL: begin
                o_cmd.step = bgst_pkg::STEP_SEG_MUL;
                n_state    = S_APPLY;
            end
            S_APPLY: begin
                // hold here until the output register can take the result
                if (w_slot_free) begin
                    o_cmd.apply = 1'b1;
                    n_oval      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_oval;

    `BGST_ASSERT(a_apply_slot_free, i_clk, i_rst_n, o_cmd.apply |-> w_slot_free, "apply while output occupied")
    `BGST_ASSERT(a_accept_starts, i_clk, i_rst_n, w_accept |=> (r_state == S_SCALE), "accepted request not started")
    `BGST_ASSERT(a_skip_on_fail, i_clk, i_rst_n, ((r_state == S_SCALE) && !i_status.sample_ok) |=> (r_state == S_APPLY), "non-sample request ran the math")
    `BGST_ASSERT(a_apply_presents, i_clk, i_rst_n, o_cmd.apply |=> (r_oval && (r_state == S_IDLE)), "applied result not presented")

endmodule

// ===== design/battery_gauge_status_tracker.sv =====
// Battery gauge status tracker: top level joining bgst_ctrl and bgst_datapath.
// Depends on bgst_pkg, bgst_ctrl, bgst_datapath.
//
// Usage:
//   Input stream (s_axis_*): one request per sample or sync. tuser selects the
//   kind (0 = ADC sample, 1 = sync of charge pin and USB link).
//   Output stream (m_axis_*): exactly one status result per request, in order.
//   Config port (i_cfg_*): write-only, one register per edge with i_cfg_we high;
//   the user must write it only while the block is idle; the block does not enforce it.
// Sequencing:
//   A successful sample walks the shared multiplier four times plus a segment
//   step before the result is applied.
//   A sync or failed sample skips the math after the scale step and goes to apply.
//   The controller takes one request at a time; tready is high only when idle.
// Reset (synchronous, active low): status and version clear to zero, config
//   registers return to threshold 20, ratio 512, active level 1, detect present 1.
// Stall: a result waits in the output register while m_axis_tready is low; the
//   next request is still accepted and computed, then holds before updating state
//   until the waiting result is taken.
module battery_gauge_status_tracker #(
    parameter int ADC_BITS     = 12,
    parameter int VERSION_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [ADC_BITS-1:0] adc_raw, then adc_ok, charge_pin_level, usb_link_seen, zero fill
    input  logic [((ADC_BITS+3+7)/8)*8-1:0] s_axis_tdata,
    // [0] operation
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] battery_available, [1] is_charging, [2] battery_low, [3] usb_link,
    // [10:4] charge level in percent, then change counter, zero fill
    output logic [((11+VERSION_BITS+7)/8)*8-1:0] m_axis_tdata,
    input  logic                            i_cfg_we,
    input  bgst_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [bgst_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IN_W  = ((ADC_BITS + 3 + 7) / 8) * 8;
    localparam int OUT_W = ((11 + VERSION_BITS + 7) / 8) * 8;

    bgst_pkg::t_dp_cmd    w_cmd;
    bgst_pkg::t_dp_status w_status;

    bgst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    bgst_datapath #(
        .ADC_BITS     (ADC_BITS),
        .VERSION_BITS (VERSION_BITS),
        .IN_W         (IN_W),
        .OUT_W        (OUT_W)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req_data (s_axis_tdata),
        .i_req_op   (s_axis_tuser),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_res_data (m_axis_tdata)
    );

endmodule
